// ===== design/neighbor_covariate_aggregator_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the neighbour covariate aggregator
// expect clk and rst_n in the scope of use
// ----------------------------------------------------------------------------
`ifndef NEIGHBOR_COVARIATE_AGGREGATOR_ASSERT_SVH
`define NEIGHBOR_COVARIATE_AGGREGATOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define NCA_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define NCA_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/nca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// shared widths, limits and types of the neighbour covariate aggregator
// ----------------------------------------------------------------------------
package nca_pkg;

  localparam int ACTOR_W    = 12;
  localparam int VALUE_W    = 32;
  localparam int AVG_W      = 32;
  localparam int TOTAL_W    = 48;
  localparam int MAX_DEGREE = 4096;
  localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int STEP_W     = $clog2(TOTAL_W);

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic signed [AVG_W-1:0]   AVG_MAX   = {1'b0, {(AVG_W-1){1'b1}}};
  localparam logic signed [AVG_W-1:0]   AVG_MIN   = {1'b1, {(AVG_W-1){1'b0}}};

  // one closed actor, handed from the accumulator to the divider
  typedef struct packed {
    logic [ACTOR_W-1:0]        actor;
    logic                      dir;
    logic                      no_ties;
    logic                      all_missing;
    logic signed [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] minimum;
    logic signed [VALUE_W-1:0] maximum;
    logic signed [VALUE_W-1:0] mean;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/nca_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca channel interfaces
// tie input, aggregate result and configuration write channels
// ----------------------------------------------------------------------------
interface nca_in_if;
  logic                               valid;
  logic                               ready;
  logic [nca_pkg::ACTOR_W-1:0]        actor_id;
  logic                               direction;
  logic                               no_ties;
  logic signed [nca_pkg::VALUE_W-1:0] alter_value;
  logic                               alter_missing;
  logic                               last_tie;

  modport source (output valid, actor_id, direction, no_ties, alter_value,
                  alter_missing, last_tie, input ready);
  modport sink (input valid, actor_id, direction, no_ties, alter_value,
                alter_missing, last_tie, output ready);
endinterface

interface nca_out_if;
  logic                               valid;
  logic                               ready;
  logic [nca_pkg::ACTOR_W-1:0]        result_actor;
  logic                               result_direction;
  logic signed [nca_pkg::TOTAL_W-1:0] total;
  logic signed [nca_pkg::AVG_W-1:0]   average;
  logic signed [nca_pkg::VALUE_W-1:0] minimum;
  logic signed [nca_pkg::VALUE_W-1:0] maximum;
  logic                               all_missing;

  modport source (output valid, result_actor, result_direction, total, average,
                  minimum, maximum, all_missing, input ready);
  modport sink (input valid, result_actor, result_direction, total, average,
                minimum, maximum, all_missing, output ready);
endinterface

interface nca_cfg_if;
  logic                               valid;
  logic                               ready;
  logic signed [nca_pkg::VALUE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/nca_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_front
// tie accumulator: total, count, min and max, closes an actor into a job
// ----------------------------------------------------------------------------
module nca_front (
  input  logic                               clk,
  input  logic                               rst_n,
  nca_in_if.sink                             in_chan,
  input  logic signed [nca_pkg::VALUE_W-1:0] mean,
  input  nca_pkg::q_status_t                 q_stat,
  output logic                               push,
  output nca_pkg::job_t                      job,
  output logic                               idle
);

  logic signed [nca_pkg::TOTAL_W-1:0] total_r, total_nxt, total_upd;
  logic [nca_pkg::CNT_W-1:0]          cnt_r, cnt_nxt, cnt_upd;
  logic signed [nca_pkg::VALUE_W-1:0] min_r, min_nxt, min_upd;
  logic signed [nca_pkg::VALUE_W-1:0] max_r, max_nxt, max_upd;
  logic                               seen_r, seen_nxt, seen_upd;
  logic signed [nca_pkg::TOTAL_W:0]   sum_wide;
  logic signed [nca_pkg::VALUE_W-1:0] val;
  logic                               accept;
  logic                               closing;

  assign in_chan.ready = !q_stat.full;
  assign accept  = in_chan.valid && in_chan.ready;
  assign closing = in_chan.no_ties || in_chan.last_tie;
  assign push    = accept && closing;
  assign idle    = (cnt_r == '0);
  assign val     = in_chan.alter_value;

  always_comb begin
    // saturating add, one guard bit catches the overflow
    sum_wide = {total_r[nca_pkg::TOTAL_W-1], total_r}
             + {{(nca_pkg::TOTAL_W + 1 - nca_pkg::VALUE_W){val[nca_pkg::VALUE_W-1]}}, val};
    if (sum_wide[nca_pkg::TOTAL_W] != sum_wide[nca_pkg::TOTAL_W-1]) begin
      total_upd = sum_wide[nca_pkg::TOTAL_W] ? nca_pkg::TOTAL_MIN : nca_pkg::TOTAL_MAX;
    end else begin
      total_upd = sum_wide[nca_pkg::TOTAL_W-1:0];
    end

    if (cnt_r < nca_pkg::CNT_W'(nca_pkg::MAX_DEGREE)) begin
      cnt_upd = cnt_r + nca_pkg::CNT_W'(1);
    end else begin
      cnt_upd = cnt_r;
    end

    min_upd  = min_r;
    max_upd  = max_r;
    seen_upd = seen_r;
    if (!in_chan.alter_missing) begin
      seen_upd = 1'b1;
      if (!seen_r || val < min_r) begin
        min_upd = val;
      end
      if (!seen_r || val > max_r) begin
        max_upd = val;
      end
    end
  end

  // job for the divider, built from the state including this tie
  always_comb begin
    job.actor   = in_chan.actor_id;
    job.dir     = in_chan.direction;
    job.no_ties = in_chan.no_ties;
    job.mean    = mean;
    if (in_chan.no_ties) begin
      job.total       = '0;
      job.count       = '0;
      job.minimum     = mean;
      job.maximum     = mean;
      job.all_missing = 1'b0;
    end else begin
      job.total       = total_upd;
      job.count       = cnt_upd;
      job.minimum     = seen_upd ? min_upd : mean;
      job.maximum     = seen_upd ? max_upd : mean;
      job.all_missing = !seen_upd;
    end
    if (in_chan.direction) begin
      job.minimum = '0;
      job.maximum = '0;
    end
  end

  always_comb begin
    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    seen_nxt  = seen_r;
    if (accept) begin
      if (closing) begin
        total_nxt = '0;
        cnt_nxt   = '0;
        min_nxt   = '0;
        max_nxt   = '0;
        seen_nxt  = 1'b0;
      end else begin
        total_nxt = total_upd;
        cnt_nxt   = cnt_upd;
        min_nxt   = min_upd;
        max_nxt   = max_upd;
        seen_nxt  = seen_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      cnt_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
      seen_r  <= 1'b0;
    end else begin
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== design/nca_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_queue
// short job queue between the accumulator and the divider
// ----------------------------------------------------------------------------
module nca_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nca_pkg::job_t      job_in,
  input  logic               pop,
  output nca_pkg::job_t      job_out,
  output nca_pkg::q_status_t q_stat
);

  nca_pkg::job_t               mem_r [nca_pkg::Q_DEPTH];
  logic [nca_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [nca_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [nca_pkg::Q_PTR_W:0]   fill_r, fill_nxt;

  assign q_stat.full  = (fill_r == (nca_pkg::Q_PTR_W + 1)'(nca_pkg::Q_DEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign job_out      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == nca_pkg::Q_PTR_W'(nca_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_r + nca_pkg::Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == nca_pkg::Q_PTR_W'(nca_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_r + nca_pkg::Q_PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + (nca_pkg::Q_PTR_W + 1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (nca_pkg::Q_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== design/nca_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_back
// bit-serial average divider and result output register
// ----------------------------------------------------------------------------
module nca_back (
  input  logic               clk,
  input  logic               rst_n,
  input  nca_pkg::job_t      job_in,
  input  nca_pkg::q_status_t q_stat,
  output logic               pop,
  nca_out_if.source          out_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  nca_pkg::job_t                      job_r;
  logic [nca_pkg::TOTAL_W-1:0]        dvd_r, dvd_nxt;
  logic [nca_pkg::CNT_W-1:0]          rem_r, rem_nxt;
  logic [nca_pkg::STEP_W-1:0]         step_r, step_nxt;
  logic                               neg_r;
  logic                               out_valid_r;
  logic [nca_pkg::CNT_W:0]            part;
  logic [nca_pkg::CNT_W:0]            trial;
  logic                               ge;
  logic                               out_free;
  logic                               load_out;
  logic                               over;
  logic signed [nca_pkg::AVG_W-1:0]   avg;

  logic [nca_pkg::ACTOR_W-1:0]        res_actor_r;
  logic                               res_dir_r;
  logic signed [nca_pkg::TOTAL_W-1:0] res_total_r;
  logic signed [nca_pkg::AVG_W-1:0]   res_avg_r;
  logic signed [nca_pkg::VALUE_W-1:0] res_min_r;
  logic signed [nca_pkg::VALUE_W-1:0] res_max_r;
  logic                               res_allmiss_r;

  assign pop      = (state_r == S_IDLE) && !q_stat.empty;
  assign out_free = !out_valid_r || out_chan.ready;
  assign load_out = (state_r == S_DONE) && out_free;

  // one restoring step: the remainder stays below the count
  assign part  = {rem_r, dvd_r[nca_pkg::TOTAL_W-1]};
  assign ge    = (part >= {1'b0, job_r.count});
  assign trial = part - {1'b0, job_r.count};

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          dvd_nxt   = job_in.total[nca_pkg::TOTAL_W-1] ? (~job_in.total + 1'b1)
                    : job_in.total;
          rem_nxt   = '0;
          step_nxt  = nca_pkg::STEP_W'(nca_pkg::TOTAL_W - 1);
          state_nxt = job_in.no_ties ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? trial[nca_pkg::CNT_W-1:0] : part[nca_pkg::CNT_W-1:0];
        dvd_nxt = {dvd_r[nca_pkg::TOTAL_W-2:0], ge};
        if (step_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - nca_pkg::STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // quotient magnitude to signed average with saturation, or the mean for an isolated actor
  always_comb begin
    if (neg_r) begin
      over = (|dvd_r[nca_pkg::TOTAL_W-1:nca_pkg::AVG_W])
          || (dvd_r[nca_pkg::AVG_W-1] && (|dvd_r[nca_pkg::AVG_W-2:0]));
      avg  = over ? nca_pkg::AVG_MIN : (~dvd_r[nca_pkg::AVG_W-1:0] + 1'b1);
    end else begin
      over = |dvd_r[nca_pkg::TOTAL_W-1:nca_pkg::AVG_W-1];
      avg  = over ? nca_pkg::AVG_MAX : dvd_r[nca_pkg::AVG_W-1:0];
    end
    if (job_r.no_ties) begin
      avg = job_r.mean;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (pop) begin
      job_r <= job_in;
      neg_r <= job_in.total[nca_pkg::TOTAL_W-1];
    end
    if (load_out) begin
      res_actor_r   <= job_r.actor;
      res_dir_r     <= job_r.dir;
      res_total_r   <= job_r.total;
      res_avg_r     <= avg;
      res_min_r     <= job_r.minimum;
      res_max_r     <= job_r.maximum;
      res_allmiss_r <= job_r.all_missing;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.result_actor     = res_actor_r;
  assign out_chan.result_direction = res_dir_r;
  assign out_chan.total            = res_total_r;
  assign out_chan.average          = res_avg_r;
  assign out_chan.minimum          = res_min_r;
  assign out_chan.maximum          = res_max_r;
  assign out_chan.all_missing      = res_allmiss_r;

endmodule

// ===== design/neighbor_covariate_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_covariate_aggregator
// per-actor total, average, minimum and maximum of neighbour covariates
// ----------------------------------------------------------------------------
// usage
//   in_chan  : one tie per item (value, missing mark, last-tie mark), or one
//              no_ties item for an isolated actor
//   out_chan : one aggregate item per actor, on its last tie or no_ties item
//   cfg_chan : writes the covariate mean, always ready, write only when idle
// throughput
//   ties are taken one per cycle while the queue has room; the accumulator
//   closes an actor in the cycle of its last tie and queues it for the
//   divider (four jobs deep); the divider is bit-serial, one quotient bit a
//   cycle over the 48-bit total, and takes a new job only once the last one
//   has left for the output register; an isolated actor skips the division
// reset
//   rst_n low clears the accumulator, the queue, the divider and the mean
// stall
//   a stalled result holds in the output register; the divider then waits,
//   the queue fills and in_chan drops ready only when the queue is full
// ----------------------------------------------------------------------------
`include "neighbor_covariate_aggregator_assert.svh"

module neighbor_covariate_aggregator (
  input  logic        clk,
  input  logic        rst_n,
  nca_in_if.sink      in_chan,
  nca_out_if.source   out_chan,
  nca_cfg_if.sink     cfg_chan
);

  // covariate mean register
  logic signed [nca_pkg::VALUE_W-1:0] mean_r;

  nca_pkg::job_t      push_job;
  nca_pkg::job_t      head_job;
  nca_pkg::q_status_t q_stat;
  logic               push;
  logic               pop;
  logic               front_idle;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      mean_r <= cfg_chan.data;
    end
  end

  // front: accumulates ties, pushes a job per closed actor
  nca_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .mean    (mean_r),
    .q_stat  (q_stat),
    .push    (push),
    .job     (push_job),
    .idle    (front_idle)
  );

  // decoupling queue
  nca_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (push_job),
    .pop     (pop),
    .job_out (head_job),
    .q_stat  (q_stat)
  );

  // back: divides total by count and presents the result
  nca_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_in   (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  // a job is never pushed into a full queue
  `NCA_ASSERT_IMP(a_push_room, push, !q_stat.full, "job pushed into full queue")
  // the divider only takes a job that is there
  `NCA_ASSERT_IMP(a_pop_held, pop, !q_stat.empty, "job popped from empty queue")
  // closing an actor leaves the accumulator cleared
  `NCA_ASSERT_NEXT(a_front_clear, push, front_idle, "accumulator not cleared")

endmodule

// ===== dv/neighbor_covariate_aggregator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_covariate_aggregator_test
// self-checking bench for the neighbour covariate aggregator: streams actors
// of ties with random gaps and back-pressure, predicts every aggregate from a
// behavioural copy of the accumulator and compares each result field by field
// ----------------------------------------------------------------------------
module neighbor_covariate_aggregator_test;

  // extremes of one covariate value
  localparam logic signed [nca_pkg::VALUE_W-1:0] VAL_MAX =
    {1'b0, {(nca_pkg::VALUE_W-1){1'b1}}};
  localparam logic signed [nca_pkg::VALUE_W-1:0] VAL_MIN =
    {1'b1, {(nca_pkg::VALUE_W-1){1'b0}}};
  // idle cycles that cover the divider after the last result
  localparam int SETTLE_CYCLES = 60;
  // ties in each long actor
  localparam int LONG_DEGREE = 64;
  // items sent by the random test
  localparam int RANDOM_ITEMS = 1150;

  // one tie item as offered on the input channel
  typedef struct {
    logic [nca_pkg::ACTOR_W-1:0]        actor_id;
    logic                               direction;
    logic                               no_ties;
    logic signed [nca_pkg::VALUE_W-1:0] alter_value;
    logic                               alter_missing;
    logic                               last_tie;
  } tie_t;

  // one aggregate as it should leave the block
  typedef struct {
    logic [nca_pkg::ACTOR_W-1:0]        actor;
    logic                               dir;
    logic signed [nca_pkg::TOTAL_W-1:0] total;
    logic signed [nca_pkg::AVG_W-1:0]   average;
    logic signed [nca_pkg::VALUE_W-1:0] minimum;
    logic signed [nca_pkg::VALUE_W-1:0] maximum;
    logic                               all_missing;
  } aggregate_t;

  logic clk;
  logic rst_n;

  nca_in_if  in_chan ();
  nca_out_if out_chan ();
  nca_cfg_if cfg_chan ();

  neighbor_covariate_aggregator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // aggregates predicted but not yet seen on the result channel
  aggregate_t pending_aggregates[$];

  // behavioural copy of the accumulator and the mean register
  logic signed [nca_pkg::VALUE_W-1:0] cov_mean;
  longint                             acc_total;
  int                                 acc_count;
  logic signed [nca_pkg::VALUE_W-1:0] acc_min;
  logic signed [nca_pkg::VALUE_W-1:0] acc_max;
  logic                               acc_seen;

  // bench control
  bit no_gaps;
  int hold_cycles;
  int errors;

  // tallies for the closing summary
  int aggregates_checked;
  int ties_taken;
  int isolated_taken;
  int mean_writes;

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic compare_field(input logic [nca_pkg::ACTOR_W-1:0] actor,
                               input string name,
                               input logic [nca_pkg::TOTAL_W-1:0] got,
                               input logic [nca_pkg::TOTAL_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("actor %0d %s got %h want %h", actor, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // predictor: folds each accepted item into the accumulator copy and queues
  // the aggregate that a closing item produces
  // ---------------------------------------------------------------------------

  task automatic clear_accumulator();
    acc_total = 0;
    acc_count = 0;
    acc_min   = '0;
    acc_max   = '0;
    acc_seen  = 1'b0;
  endtask

  task automatic accumulate_tie(input tie_t t);
    longint     sum;
    longint     avg;
    aggregate_t agg;
    agg.actor = t.actor_id;
    agg.dir   = t.direction;
    if (t.no_ties) begin
      // isolated actor: average and extremes fall back to the mean, the total is zero, any open actor is dropped
      isolated_taken++;
      agg.total       = '0;
      agg.average     = cov_mean;
      agg.minimum     = cov_mean;
      agg.maximum     = cov_mean;
      agg.all_missing = 1'b0;
    end else begin
      ties_taken++;
      // missing values still add to the total and the count
      sum = acc_total + longint'(t.alter_value);
      if (sum > nca_pkg::TOTAL_MAX) sum = nca_pkg::TOTAL_MAX;
      if (sum < nca_pkg::TOTAL_MIN) sum = nca_pkg::TOTAL_MIN;
      acc_total = sum;
      if (acc_count < nca_pkg::MAX_DEGREE) acc_count++;
      if (!t.alter_missing) begin
        if (!acc_seen) begin
          acc_min  = t.alter_value;
          acc_max  = t.alter_value;
          acc_seen = 1'b1;
        end else begin
          if (t.alter_value < acc_min) acc_min = t.alter_value;
          if (t.alter_value > acc_max) acc_max = t.alter_value;
        end
      end
      if (!t.last_tie) return;
      // signed division truncates toward zero, then clamp to the average width
      avg = acc_total / longint'(acc_count);
      if (avg > nca_pkg::AVG_MAX) avg = nca_pkg::AVG_MAX;
      if (avg < nca_pkg::AVG_MIN) avg = nca_pkg::AVG_MIN;
      agg.total       = acc_total[nca_pkg::TOTAL_W-1:0];
      agg.average     = avg[nca_pkg::AVG_W-1:0];
      agg.all_missing = !acc_seen;
      agg.minimum     = acc_seen ? acc_min : cov_mean;
      agg.maximum     = acc_seen ? acc_max : cov_mean;
    end
    // in-tie aggregates carry no extremes; the closing item decides the direction
    if (t.direction) begin
      agg.minimum = '0;
      agg.maximum = '0;
    end
    pending_aggregates.push_back(agg);
    clear_accumulator();
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every accepted aggregate against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_aggregate
    aggregate_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      aggregates_checked++;
      if (pending_aggregates.size() == 0) begin
        report_mismatch($sformatf("aggregate for actor %0d with none pending",
                                  out_chan.result_actor));
      end else begin
        want = pending_aggregates.pop_front();
        compare_field(want.actor, "actor", nca_pkg::TOTAL_W'(out_chan.result_actor),
                      nca_pkg::TOTAL_W'(want.actor));
        compare_field(want.actor, "direction",
                      nca_pkg::TOTAL_W'(out_chan.result_direction),
                      nca_pkg::TOTAL_W'(want.dir));
        compare_field(want.actor, "total", out_chan.total, want.total);
        compare_field(want.actor, "average", nca_pkg::TOTAL_W'(out_chan.average),
                      nca_pkg::TOTAL_W'(want.average));
        compare_field(want.actor, "minimum", nca_pkg::TOTAL_W'(out_chan.minimum),
                      nca_pkg::TOTAL_W'(want.minimum));
        compare_field(want.actor, "maximum", nca_pkg::TOTAL_W'(out_chan.maximum),
                      nca_pkg::TOTAL_W'(want.maximum));
        compare_field(want.actor, "all_missing", nca_pkg::TOTAL_W'(out_chan.all_missing),
                      nca_pkg::TOTAL_W'(want.all_missing));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result-side ready: random stalls, a calm stretch, and long hold-offs on
  // request, counted down here one cycle at a time
  // ---------------------------------------------------------------------------

  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_chan.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_chan.ready <= no_gaps || ($urandom_range(99) >= 8);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tie_t make_tie(input logic [nca_pkg::ACTOR_W-1:0] actor,
                                    input logic dir, input logic isolated,
                                    input logic signed [nca_pkg::VALUE_W-1:0] value,
                                    input logic missing, input logic last);
    tie_t t;
    t.actor_id      = actor;
    t.direction     = dir;
    t.no_ties       = isolated;
    t.alter_value   = value;
    t.alter_missing = missing;
    t.last_tie      = last;
    return t;
  endfunction

  // covariate value weighted toward the extremes and small magnitudes
  function automatic logic signed [nca_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return int'($urandom_range(200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  // offers one item from a falling edge and returns at the accepting rising edge;
  // valid is left high so that back-to-back items need no second assignment
  task automatic send_tie(input tie_t t);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.actor_id      <= t.actor_id;
    in_chan.direction     <= t.direction;
    in_chan.no_ties       <= t.no_ties;
    in_chan.alter_value   <= t.alter_value;
    in_chan.alter_missing <= t.alter_missing;
    in_chan.last_tie      <= t.last_tie;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    accumulate_tie(t);
  endtask

  // drop valid and wait until every predicted aggregate has come back
  task automatic wait_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_aggregates.size() != 0) @(posedge clk);
  endtask

  // the mean register is only written with the block idle
  task automatic write_mean(input logic signed [nca_pkg::VALUE_W-1:0] value);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= value;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    cov_mean = value;
    mean_writes++;
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // one actor of random shape; returns the number of items it took
  task automatic send_random_actor(output int sent);
    int                          kind;
    int                          degree;
    int                          miss_pct;
    int                          i;
    logic                        dir;
    logic                        mixed;
    logic [nca_pkg::ACTOR_W-1:0] actor;
    kind  = $urandom_range(99);
    actor = nca_pkg::ACTOR_W'($urandom);
    dir   = 1'($urandom_range(1));
    sent  = 0;
    if (kind < 8) begin
      // isolated actor, the value fields are don't-care
      send_tie(make_tie(actor, dir, 1'b1, pick_value(), 1'($urandom_range(1)),
                        1'($urandom_range(1))));
      sent = 1;
      return;
    end
    degree   = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
    miss_pct = (kind < 20) ? 100 : ($urandom_range(1) ? 25 : 0);
    mixed    = ($urandom_range(9) == 0);
    for (i = 0; i < degree; i++) begin
      // kinds 8 to 11 never close, so their ties run into the next actor
      send_tie(make_tie(actor, mixed ? 1'($urandom_range(1)) : dir, 1'b0, pick_value(),
                        $urandom_range(99) < miss_pct, i == degree - 1 && kind >= 12));
      sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked actors: extremes, both directions, isolated, all missing,
  // a discarded partial actor, mixed directions and truncation of negatives
  task automatic test_directed();
    write_mean(32'sh0001_8000);
    send_tie(make_tie(12'd0,    1'b0, 1'b0, VAL_MAX, 1'b0, 1'b1));
    send_tie(make_tie(12'd4095, 1'b0, 1'b0, VAL_MIN, 1'b0, 1'b1));
    // missing tie in the middle still counts toward total and count
    send_tie(make_tie(12'd7, 1'b0, 1'b0, 5,   1'b0, 1'b0));
    send_tie(make_tie(12'd7, 1'b0, 1'b0, -20, 1'b1, 1'b0));
    send_tie(make_tie(12'd7, 1'b0, 1'b0, -2,  1'b0, 1'b1));
    send_tie(make_tie(12'd9, 1'b1, 1'b0, 100, 1'b0, 1'b0));
    send_tie(make_tie(12'd9, 1'b1, 1'b0, -7,  1'b0, 1'b1));
    // every tie missing: extremes fall back to the mean
    send_tie(make_tie(12'd10, 1'b0, 1'b0, 3,  1'b1, 1'b0));
    send_tie(make_tie(12'd10, 1'b0, 1'b0, 4,  1'b1, 1'b1));
    send_tie(make_tie(12'd11, 1'b1, 1'b0, -9, 1'b1, 1'b1));
    send_tie(make_tie(12'd17, 1'b0, 1'b0, 32'sh1234_5678, 1'b1, 1'b1));
    // isolated actors, with and without the last mark
    send_tie(make_tie(12'd12, 1'b0, 1'b1, VAL_MAX, 1'b1, 1'b0));
    send_tie(make_tie(12'd13, 1'b1, 1'b1, VAL_MIN, 1'b0, 1'b1));
    // an isolated item throws away the open actor
    send_tie(make_tie(12'd14, 1'b0, 1'b0, 55, 1'b0, 1'b0));
    send_tie(make_tie(12'd14, 1'b0, 1'b1, 0,  1'b0, 1'b1));
    // direction of the closing item wins
    send_tie(make_tie(12'd15, 1'b0, 1'b0, -1, 1'b0, 1'b0));
    send_tie(make_tie(12'd15, 1'b1, 1'b0, 2,  1'b0, 1'b1));
    // -7 / 2 truncates to -3
    send_tie(make_tie(12'd16, 1'b0, 1'b0, -3, 1'b0, 1'b0));
    send_tie(make_tie(12'd16, 1'b0, 1'b0, -4, 1'b0, 1'b1));
    send_tie(make_tie(12'd18, 1'b0, 1'b0, -1, 1'b0, 1'b0));
    send_tie(make_tie(12'd18, 1'b0, 1'b0, -1, 1'b0, 1'b1));
    wait_drain();
  endtask

  // a few actors under each mean setting, the extremes among them
  task automatic test_mean_settings();
    logic signed [nca_pkg::VALUE_W-1:0] means[5];
    int                                 m;
    means = '{VAL_MIN, VAL_MAX, -1, 0, $urandom};
    for (m = 0; m < 5; m++) begin
      write_mean(means[m]);
      send_tie(make_tie(nca_pkg::ACTOR_W'($urandom), 1'b0, 1'b1, pick_value(), 1'b0, 1'b1));
      send_tie(make_tie(nca_pkg::ACTOR_W'($urandom), 1'b1, 1'b1, pick_value(), 1'b1, 1'b0));
      send_tie(make_tie(12'd200, 1'b0, 1'b0, pick_value(), 1'b1, 1'b0));
      send_tie(make_tie(12'd200, 1'b0, 1'b0, pick_value(), 1'b1, 1'b1));
      send_tie(make_tie(12'd201, 1'b0, 1'b0, pick_value(), 1'b0, 1'b0));
      send_tie(make_tie(12'd201, 1'b0, 1'b0, pick_value(), 1'b1, 1'b1));
    end
  endtask

  // long runs of extreme values, so the total grows far past one value
  task automatic test_long_actors();
    int i;
    for (i = 0; i < LONG_DEGREE; i++)
      send_tie(make_tie(12'd101, 1'b0, 1'b0, VAL_MAX, 1'b0, i == LONG_DEGREE - 1));
    for (i = 0; i < LONG_DEGREE; i++)
      send_tie(make_tie(12'd102, 1'b1, 1'b0, VAL_MIN, $urandom_range(7) == 0,
                        i == LONG_DEGREE - 1));
  endtask

  // results held off for a long stretch while closing items keep coming,
  // so the job queue fills and the input stalls
  task automatic test_backpressure();
    int i;
    hold_cycles = 400;
    for (i = 0; i < 30; i++)
      send_tie(make_tie(nca_pkg::ACTOR_W'($urandom), 1'($urandom_range(1)), i % 5 == 0,
                        pick_value(), 1'($urandom_range(1)), 1'b1));
    wait_drain();
  endtask

  // random actors, with a calm stretch, periodic drains and mean changes
  task automatic test_random();
    int items;
    int n;
    int next_pause;
    int next_cfg;
    items      = 0;
    next_pause = 200;
    next_cfg   = 450;
    while (items < RANDOM_ITEMS) begin
      no_gaps = (items >= 550 && items < 800);
      send_random_actor(n);
      items += n;
      // only touch the mean with no actor open
      if (items >= next_cfg && acc_count == 0) begin
        write_mean(pick_value());
        next_cfg += 450;
      end else if (items >= next_pause) begin
        wait_drain();
        next_pause += 200;
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.actor_id      = '0;
    in_chan.direction     = 1'b0;
    in_chan.no_ties       = 1'b0;
    in_chan.alter_value   = '0;
    in_chan.alter_missing = 1'b0;
    in_chan.last_tie      = 1'b0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.data         = '0;
    no_gaps               = 1'b0;
    hold_cycles           = 0;
    errors                = 0;
    cov_mean              = '0;
    clear_accumulator();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_mean_settings();
    test_backpressure();
    test_long_actors();
    test_random();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d aggregates from %0d ties and %0d isolated actors, %0d mean writes",
             aggregates_checked, ties_taken, isolated_taken, mean_writes);
    $display("both directions, missing and mixed ties, long actors and full-queue stalls");
    if (errors == 0)
      $display("** neighbor_covariate_aggregator: PASSED **");
    else
      $display("** neighbor_covariate_aggregator: FAILED **");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("timeout with %0d aggregates pending", pending_aggregates.size());
    $display("** neighbor_covariate_aggregator: FAILED **");
    $finish;
  end

endmodule
